FILE: hdl/psd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// shared types and constants of the pkt-line side-band deframer
// ----------------------------------------------------------------------------
package psd_pkg;

   // event codes of a result beat
   localparam logic [1:0] EV_DATA  = 2'd0;
   localparam logic [1:0] EV_FLUSH = 2'd1;
   localparam logic [1:0] EV_NAK   = 2'd2;
   localparam logic [1:0] EV_BAD   = 2'd3;

   // depth of the queue between front and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // classification of the current packet payload
   typedef enum logic [1:0] {
      CLS_UNDECIDED = 2'd0,
      CLS_FORWARD   = 2'd1,
      CLS_PROGRESS  = 2'd2,
      CLS_NAK       = 2'd3
   } psd_class_type;

   // one queue entry: all results caused by one input beat, in order
   typedef struct packed {
      logic [1:0]      cnt;   // number of results, 1 to 3
      logic [1:0]      ev;    // event code (non-data entries carry one result)
      logic [2:0][7:0] data;  // payload bytes, data[0] leaves first
      logic            pend;  // packet end flag for the final byte
   } psd_entry_type;

   // queue status seen by the back end
   typedef struct packed {
      logic empty;
      logic full;
   } psd_qstat_type;

endpackage

FILE: hdl/psd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_front
// header parsing and payload classification, one byte per cycle while accept is high
// ----------------------------------------------------------------------------
module psd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             in_byte,
   output logic                   push,
   output psd_pkg::psd_entry_type entry
);

   localparam logic [7:0]  PROGRESS_BAND = 8'h02;
   localparam logic [7:0]  CHR_N         = 8'h4e;
   localparam logic [7:0]  CHR_A         = 8'h41;
   localparam logic [7:0]  CHR_K         = 8'h4b;
   localparam logic [7:0]  CHR_LF        = 8'h0a;
   localparam logic [15:0] HEADER_BYTES  = 16'd4;
   localparam logic [15:0] NAK_LENGTH    = 16'd8;

   logic                  in_header_ff, in_header_in;
   logic [1:0]            digit_count_ff, digit_count_in;
   logic [15:0]           packet_length_ff, packet_length_in;
   logic [15:0]           bytes_consumed_ff, bytes_consumed_in;
   psd_pkg::psd_class_type packet_class_ff, packet_class_in;
   logic [15:0]           held_bytes_ff, held_bytes_in;
   logic [1:0]            held_count_ff, held_count_in;

   logic                  hex_ok;
   logic [3:0]            hex_val;
   logic [15:0]           length_shift;
   logic [15:0]           consumed_inc;
   logic                  final_byte;
   logic [7:0]            nak_expect;
   logic                  nak_match;
   logic                  entry_valid;

   // ascii hex digit decode, either case
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         hex_val = 4'(in_byte - 8'h30);
      end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
         hex_val = 4'(in_byte - 8'h57);
      end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
         hex_val = 4'(in_byte - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign length_shift = {packet_length_ff[11:0], hex_val};
   assign consumed_inc = 16'(bytes_consumed_ff + 16'd1);
   assign final_byte   = (consumed_inc >= packet_length_ff);

   always_comb begin
      case (held_count_ff)
         2'd0:    nak_expect = CHR_A;
         2'd1:    nak_expect = CHR_K;
         default: nak_expect = CHR_LF;
      endcase
   end
   assign nak_match = (in_byte == nak_expect);

   // next state
   always_comb begin
      in_header_in      = in_header_ff;
      digit_count_in    = digit_count_ff;
      packet_length_in  = packet_length_ff;
      bytes_consumed_in = bytes_consumed_ff;
      packet_class_in   = packet_class_ff;
      held_bytes_in     = held_bytes_ff;
      held_count_in     = held_count_ff;
      if (in_header_ff) begin
         if (!hex_ok) begin
            digit_count_in   = 2'd0;
            packet_length_in = 16'd0;
         end else begin
            packet_length_in = length_shift;
            digit_count_in   = 2'(digit_count_ff + 2'd1);
            if (digit_count_ff == 2'd3 && length_shift > HEADER_BYTES) begin
               in_header_in      = 1'b0;
               bytes_consumed_in = HEADER_BYTES;
               packet_class_in   = psd_pkg::CLS_UNDECIDED;
               held_bytes_in     = 16'd0;
               held_count_in     = 2'd0;
            end
         end
      end else begin
         bytes_consumed_in = consumed_inc;
         case (packet_class_ff)
            psd_pkg::CLS_UNDECIDED: begin
               if (in_byte == PROGRESS_BAND) begin
                  packet_class_in = psd_pkg::CLS_PROGRESS;
               end else if (packet_length_ff == NAK_LENGTH && in_byte == CHR_N) begin
                  packet_class_in = psd_pkg::CLS_NAK;
               end else begin
                  packet_class_in = psd_pkg::CLS_FORWARD;
               end
            end
            psd_pkg::CLS_NAK: begin
               if (nak_match) begin
                  if (held_count_ff != 2'd2) begin
                     held_bytes_in = {held_bytes_ff[7:0], in_byte};
                     held_count_in = 2'(held_count_ff + 2'd1);
                  end
               end else begin
                  packet_class_in = psd_pkg::CLS_FORWARD;
                  held_bytes_in   = 16'd0;
                  held_count_in   = 2'd0;
               end
            end
            default: begin
            end
         endcase
         if (final_byte) begin
            in_header_in    = 1'b1;
            digit_count_in  = 2'd0;
            packet_class_in = psd_pkg::CLS_UNDECIDED;
            held_bytes_in   = 16'd0;
            held_count_in   = 2'd0;
         end
      end
   end

   // queue entry for this beat
   always_comb begin
      entry_valid = 1'b0;
      entry.cnt   = 2'd1;
      entry.ev    = psd_pkg::EV_DATA;
      entry.data  = '0;
      entry.pend  = 1'b0;
      if (in_header_ff) begin
         if (!hex_ok) begin
            entry_valid = 1'b1;
            entry.ev    = psd_pkg::EV_BAD;
         end else if (digit_count_ff == 2'd3) begin
            if (length_shift == 16'd0) begin
               entry_valid = 1'b1;
               entry.ev    = psd_pkg::EV_FLUSH;
            end else if (length_shift < HEADER_BYTES) begin
               entry_valid = 1'b1;
               entry.ev    = psd_pkg::EV_BAD;
            end
         end
      end else begin
         case (packet_class_ff)
            psd_pkg::CLS_FORWARD: begin
               entry_valid   = 1'b1;
               entry.data[0] = in_byte;
               entry.pend    = final_byte;
            end
            psd_pkg::CLS_NAK: begin
               if (nak_match) begin
                  if (held_count_ff == 2'd2) begin
                     entry_valid = 1'b1;
                     entry.ev    = psd_pkg::EV_NAK;
                  end
               end else begin
                  entry_valid = 1'b1;
                  entry.pend  = final_byte;
                  case (held_count_ff)
                     2'd0: begin
                        entry.data[0] = in_byte;
                     end
                     2'd1: begin
                        entry.cnt     = 2'd2;
                        entry.data[0] = held_bytes_ff[7:0];
                        entry.data[1] = in_byte;
                     end
                     default: begin
                        entry.cnt     = 2'd3;
                        entry.data[0] = held_bytes_ff[15:8];
                        entry.data[1] = held_bytes_ff[7:0];
                        entry.data[2] = in_byte;
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign push = accept & entry_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_header_ff      <= 1'b1;
         digit_count_ff    <= 2'd0;
         packet_length_ff  <= 16'd0;
         bytes_consumed_ff <= 16'd0;
         packet_class_ff   <= psd_pkg::CLS_UNDECIDED;
         held_bytes_ff     <= 16'd0;
         held_count_ff     <= 2'd0;
      end else if (accept) begin
         in_header_ff      <= in_header_in;
         digit_count_ff    <= digit_count_in;
         packet_length_ff  <= packet_length_in;
         bytes_consumed_ff <= bytes_consumed_in;
         packet_class_ff   <= packet_class_in;
         held_bytes_ff     <= held_bytes_in;
         held_count_ff     <= held_count_in;
      end
   end

endmodule

FILE: hdl/psd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_queue
// short first-in first-out queue of result entries
// ----------------------------------------------------------------------------
module psd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  psd_pkg::psd_entry_type push_entry,
   input  logic                   pop,
   output psd_pkg::psd_entry_type head,
   output psd_pkg::psd_qstat_type stat
);

   psd_pkg::psd_entry_type          mem_ff [psd_pkg::QUEUE_DEPTH];
   logic [psd_pkg::QPTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [psd_pkg::QCNT_W-1:0]      count_ff;
   logic                            do_push, do_pop;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == psd_pkg::QCNT_W'(psd_pkg::QUEUE_DEPTH));
   assign do_push    = push & ~stat.full;
   assign do_pop     = pop & ~stat.empty;
   assign head       = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= psd_pkg::QPTR_W'(wr_ptr_ff + 1'b1);
         end
         if (do_pop) begin
            rd_ptr_ff <= psd_pkg::QPTR_W'(rd_ptr_ff + 1'b1);
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= psd_pkg::QCNT_W'(count_ff + 1'b1);
            2'b01:   count_ff <= psd_pkg::QCNT_W'(count_ff - 1'b1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: hdl/psd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_back
// unpacks queue entries into result beats, one beat per cycle while rsp_ready is high
// ----------------------------------------------------------------------------
module psd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  psd_pkg::psd_entry_type head,
   input  psd_pkg::psd_qstat_type stat,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_event_res,
   output logic [7:0]             rsp_payload_byte,
   output logic                   rsp_packet_end,
   output logic                   rsp_last
);

   psd_pkg::psd_entry_type cur_ff, cur_in;
   logic                   cur_valid_ff, cur_valid_in;
   logic [1:0]             idx_ff, idx_in;
   logic                   take, at_last, load;

   assign at_last = (idx_ff == 2'(cur_ff.cnt - 2'd1));
   assign take    = cur_valid_ff & rsp_ready;
   assign load    = ~cur_valid_ff | (take & at_last);
   assign pop     = load & ~stat.empty;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_in       = head;
         cur_valid_in = ~stat.empty;
         idx_in       = 2'd0;
      end else if (take) begin
         idx_in = 2'(idx_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_payload_byte = cur_ff.data[0];
         2'd1:    rsp_payload_byte = cur_ff.data[1];
         default: rsp_payload_byte = cur_ff.data[2];
      endcase
   end

   assign rsp_valid      = cur_valid_ff;
   assign rsp_event_res  = cur_ff.ev;
   assign rsp_packet_end = cur_ff.pend & at_last;
   assign rsp_last       = at_last;

endmodule

FILE: hdl/pktline_sideband_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pktline_sideband_deframer_top
// pkt-line side-band deframer: header parse, band demux, NAK and flush events
// ----------------------------------------------------------------------------
// One input byte is taken per req_ beat, and a byte can be taken in every
// cycle in which the queue is not full. Each packet opens with four hex
// digits (either case) giving the length including the header; 0000 gives a
// flush event, a non-hex digit or a length of 1 to 3 gives a bad-header
// event, a payload of exactly "NAK\n" gives a NAK event, a payload opening
// with band 2 is dropped, and any other payload is forwarded without its
// band byte, packet_end marking the final forwarded byte. A byte causes
// zero to three result beats; rsp_last marks the final one. Result beats
// leave at one per cycle while rsp_ready is high, so a byte that causes two
// or three beats holds the result port for each of them, and the four entry
// queue between front and back end soaks this up until it is full. A result
// beat reaches rsp_ through the queue memory and the back end register.
// ----------------------------------------------------------------------------
module pktline_sideband_deframer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_event_res,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_packet_end,
   output logic       rsp_last
);

   // front to queue
   logic                   push;
   psd_pkg::psd_entry_type push_entry;
   // queue to back
   logic                   pop;
   psd_pkg::psd_entry_type head;
   psd_pkg::psd_qstat_type stat;
   logic                   accept;

   // a byte is taken whenever the queue has room for whatever it causes
   assign req_ready = ~stat.full;
   assign accept    = req_valid & req_ready;

   // header and payload classification
   psd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .push    (push),
      .entry   (push_entry)
   );

   // decoupling queue
   psd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .stat       (stat)
   );

   // result beat sequencing and output register
   psd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .stat             (stat),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_last         (rsp_last)
   );

endmodule
